// ===== hdl/rtsd_pkg.sv =====
package rtsd_pkg;

	localparam int WORD_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int START_W    = 14;
	localparam int LENGTH_W   = 15;
	localparam int CHAN_W     = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_DATA_W-1:0] TEXTURE_BYTES_RST = 16'h8000;
	localparam logic [WORD_W-1:0]     LITERAL_MASK      = 16'hFF00;
	localparam logic [CHAN_W-1:0]     ALPHA_OPAQUE      = 8'hFF;
	localparam logic [CHAN_W-1:0]     ALPHA_CLEAR       = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COMPRESSED_MODE = 2'd0,
		REG_TEXTURE_BYTES   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [START_W-1:0]  span_start;
		logic [LENGTH_W-1:0] span_length;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [CHAN_W-1:0]   alpha;
		logic                final_span;
	} span_t;

	typedef struct packed {
		logic [1:0] count;
		span_t      first;
		span_t      second;
	} span_pair_t;

	function automatic span_t make_span(
		input logic [START_W-1:0]  start,
		input logic [LENGTH_W-1:0] len,
		input logic [WORD_W-1:0]   colour,
		input logic                opaque,
		input logic                last
	);
		span_t s;
		s.span_start  = start;
		s.span_length = len;
		s.red         = opaque ? {colour[4:0], 3'b000} : ALPHA_CLEAR;
		s.green       = opaque ? {colour[9:5], 3'b000} : ALPHA_CLEAR;
		s.blue        = opaque ? {colour[14:10], 3'b000} : ALPHA_CLEAR;
		s.alpha       = opaque ? ALPHA_OPAQUE : ALPHA_CLEAR;
		s.final_span  = last;
		return s;
	endfunction

endpackage

// ===== hdl/rtsd_if.sv =====
interface rtsd_word_if import rtsd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic              end_of_data;

	modport source (output valid, output data_word, output end_of_data, input ready);
	modport sink (input valid, input data_word, input end_of_data, output ready);
endinterface

interface rtsd_span_if import rtsd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [START_W-1:0]  span_start;
	logic [LENGTH_W-1:0] span_length;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;
	logic [CHAN_W-1:0]   alpha;
	logic                final_span;

	modport source (output valid, output span_start, output span_length, output red,
		output green, output blue, output alpha, output final_span, input ready);
	modport sink (input valid, input span_start, input span_length, input red,
		input green, input blue, input alpha, input final_span, output ready);
endinterface

interface rtsd_cfg_if import rtsd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rtsd_decode.sv =====
module rtsd_decode import rtsd_pkg::*; #(
	parameter int TEXEL_COUNT = 16384
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [WORD_W-1:0]     data_word,
	input  logic                  end_of_data,
	input  logic                  compressed_mode,
	input  logic [CFG_DATA_W-1:0] texture_bytes,
	output span_pair_t            spans
);

	localparam int CW = $clog2(TEXEL_COUNT + 1);
	localparam int LW = (CW > WORD_W) ? CW : WORD_W;
	localparam logic [CW-1:0] COUNT_C  = CW'(TEXEL_COUNT);
	localparam logic [17:0]   RAW_NEED = 18'(2 * TEXEL_COUNT);

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_CONTROL,
		PH_LITERAL,
		PH_REPEAT
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [CW-1:0] tw_q, tw_d, tw_mid, left, fill_len;
	logic [1:0]   prefix_q, prefix_d, prefix_inc;
	logic [8:0]   literal_q, literal_d, literal_dec;
	logic [15:0]  repeat_q, repeat_d;
	logic [LW-1:0] dec_len;
	logic         dec_valid, fill_valid;
	span_t        dec_span, fill_span;

	always_comb begin
		phase_d     = phase_q;
		prefix_d    = prefix_q;
		literal_d   = literal_q;
		repeat_d    = repeat_q;
		dec_valid   = 1'b0;
		dec_len     = LW'(1);
		left        = COUNT_C - tw_q;
		prefix_inc  = prefix_q + 2'd1;
		literal_dec = literal_q;
		if (tw_q < COUNT_C) begin
			if (!compressed_mode) begin
				dec_valid = ({2'b00, texture_bytes} >= RAW_NEED);
			end else begin
				unique case (phase_q)
					PH_SKIP: begin
						prefix_d = prefix_inc;
						if (prefix_inc >= 2'd2) begin
							phase_d = PH_CONTROL;
						end
					end
					PH_CONTROL: begin
						if ((data_word & LITERAL_MASK) == LITERAL_MASK) begin
							literal_d = 9'(~data_word + 16'd1);
							phase_d   = PH_LITERAL;
						end else begin
							repeat_d = data_word;
							phase_d  = PH_REPEAT;
						end
					end
					PH_LITERAL: begin
						dec_valid = 1'b1;
						if (literal_q != 9'd0) begin
							literal_dec = literal_q - 9'd1;
						end
						literal_d = literal_dec;
						if (literal_dec == 9'd0) begin
							phase_d = PH_CONTROL;
						end
					end
					PH_REPEAT: begin
						dec_len   = (LW'(repeat_q) < LW'(left)) ? LW'(repeat_q) : LW'(left);
						dec_valid = (dec_len != '0);
						repeat_d  = 16'd0;
						phase_d   = PH_CONTROL;
					end
				endcase
			end
		end
		tw_mid     = dec_valid ? tw_q + CW'(dec_len) : tw_q;
		fill_valid = end_of_data && (tw_mid < COUNT_C);
		fill_len   = COUNT_C - tw_mid;
		tw_d       = tw_mid;
		if (end_of_data) begin
			tw_d      = '0;
			phase_d   = PH_SKIP;
			prefix_d  = 2'd0;
			literal_d = 9'd0;
			repeat_d  = 16'd0;
		end

		dec_span  = make_span(START_W'(tw_q), LENGTH_W'(dec_len), data_word, 1'b1,
			end_of_data && !fill_valid);
		fill_span = make_span(START_W'(tw_mid), LENGTH_W'(fill_len), '0, 1'b0, 1'b1);

		spans.count  = 2'(dec_valid) + 2'(fill_valid);
		spans.first  = dec_valid ? dec_span : fill_span;
		spans.second = fill_span;
		if (!step) begin
			spans.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			tw_q      <= '0;
			prefix_q  <= 2'd0;
			literal_q <= 9'd0;
			repeat_q  <= 16'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			tw_q      <= tw_d;
			prefix_q  <= prefix_d;
			literal_q <= literal_d;
			repeat_q  <= repeat_d;
		end
	end

endmodule

// ===== hdl/rtsd_span_fifo.sv =====
module rtsd_span_fifo import rtsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  span_pair_t push,
	output logic       room,
	output logic       head_valid,
	output span_t      head,
	input  logic       pop
);

	span_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign room       = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(do_pop);
			count_q  <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);
		end
	end

endmodule

// ===== hdl/rle_texel_span_decoder.sv =====
// Channel  Direction  Beat contents
// words    in         data_word, end_of_data
// spans    out        span_start, span_length, red, green, blue, alpha, final_span
// cfg      in         index (0 compressed_mode, 1 texture_bytes), data
//
// A word is registered at acceptance and decoded, once the queue has room, into zero, one or two
// spans, which enter a four-entry span queue; one word per cycle is accepted while the
// queue has room for two spans, and spans leave at up to one per cycle while the span side
// is ready. Reset clears the decode state and loads the register defaults.
// A stall on the span side fills the queue and then holds the word register.
module rle_texel_span_decoder import rtsd_pkg::*; #(
	parameter int TEXEL_COUNT = 16384
) (
	input logic         clk,
	input logic         arst_n,
	rtsd_word_if.sink   words,
	rtsd_span_if.source spans,
	rtsd_cfg_if.sink    cfg
);

	logic                  compressed_mode_q;
	logic [CFG_DATA_W-1:0] texture_bytes_q;
	logic                  valid_s1;
	logic [WORD_W-1:0]     word_s1;
	logic                  eod_s1;
	logic                  advance, room;
	span_pair_t            pair;
	span_t                 head;

	assign cfg.ready   = 1'b1;
	assign advance     = valid_s1 && room;
	assign words.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_mode_q <= 1'b0;
			texture_bytes_q   <= TEXTURE_BYTES_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COMPRESSED_MODE: compressed_mode_q <= cfg.data[0];
				REG_TEXTURE_BYTES:   texture_bytes_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1 <= words.data_word;
			eod_s1  <= words.end_of_data;
		end
	end

	rtsd_decode #(
		.TEXEL_COUNT(TEXEL_COUNT)
	) u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.data_word       (word_s1),
		.end_of_data     (eod_s1),
		.compressed_mode (compressed_mode_q),
		.texture_bytes   (texture_bytes_q),
		.spans           (pair)
	);

	rtsd_span_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (pair),
		.room       (room),
		.head_valid (spans.valid),
		.head       (head),
		.pop        (spans.ready)
	);

	assign spans.span_start  = head.span_start;
	assign spans.span_length = head.span_length;
	assign spans.red         = head.red;
	assign spans.green       = head.green;
	assign spans.blue        = head.blue;
	assign spans.alpha       = head.alpha;
	assign spans.final_span  = head.final_span;

endmodule
